// ----- sv/hmm_forward_state_step_defines.svh -----
// ----------------------------------------------------------------------------
// hmm_forward_state_step_defines.svh
// Assertion macros shared by the forward state step RTL.
// ----------------------------------------------------------------------------
`ifndef HMM_FORWARD_STATE_STEP_DEFINES_SVH
`define HMM_FORWARD_STATE_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HFS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HFS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hfs_pkg.sv -----
// ----------------------------------------------------------------------------
// hfs_pkg
// Types and constants shared by the forward state step modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hfs_pkg;

  // Field width on the stream buses
  localparam int FIELD_W = 32;

  // in_tdata layout, lowest bit first
  localparam int OFF_ALPHA  = 0;
  localparam int OFF_SUFFIX = 32;
  localparam int OFF_DIAG   = 64;
  localparam int OFF_BELOW  = 96;
  localparam int OFF_UPPREV = 128;
  localparam int OFF_RATIO  = 160;
  localparam int OFF_EBASE  = 192;
  localparam int OFF_EZERO  = 224;
  localparam int OFF_ETWO   = 256;
  localparam int OFF_OBSZ   = 288;
  localparam int OFF_OBST   = 289;
  localparam int IN_TDATA_W = 296;
  localparam int OUT_TDATA_W = 32;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RT   = 7'b0000010,
    ST_DG   = 7'b0000100,
    ST_BL   = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_EM   = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD  = 2'd0,
    ACC_LOAD  = 2'd1,
    ACC_ADD   = 2'd2,
    ACC_CLEAR = 2'd3
  } acc_op_t;

  // Emission register operation
  typedef enum logic [1:0] {
    EMIS_HOLD = 2'd0,
    EMIS_LOAD = 2'd1,
    EMIS_ADD  = 2'd2
  } emis_op_t;

  // Multiplier operand pair
  typedef enum logic [2:0] {
    OPS_UP = 3'd0,
    OPS_RT = 3'd1,
    OPS_DG = 3'd2,
    OPS_BL = 3'd3,
    OPS_EM = 3'd4
  } op_sel_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic     mul_en;
    op_sel_t  op_sel;
    acc_op_t  acc_op;
    emis_op_t emis_op;
    logic     cap_in;
    logic     upd_upper;
    logic     load_out;
  } ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic accept;
    logic first;
    logic out_stall;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/hfs_mac_unit.sv -----
// ----------------------------------------------------------------------------
// hfs_mac_unit
// Shared fixed-point multiply, scale and saturating accumulate unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfs_mac_unit #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire hfs_pkg::ctrl_t      ctrl,
  input  wire logic signed [W-1:0] op_a,
  input  wire logic signed [W-1:0] op_b,
  input  wire logic signed [W-1:0] emis_x,
  input  wire logic signed [W-1:0] emis_y,
  output logic signed [W-1:0]      acc,
  output logic signed [W-1:0]      emis,
  output logic signed [W-1:0]      scaled
);
  import hfs_pkg::*;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [2*W-1:0] prod_r;
  logic signed [W-1:0]   acc_r, acc_nxt;
  logic signed [W-1:0]   emis_r, emis_nxt;

  // Saturating add of two W-bit values
  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sat_add = s[W] ? SMIN : SMAX;
    else                sat_add = s[W-1:0];
  endfunction

  // Product scaled by 2^-(W-2), floor, then saturated
  function automatic logic signed [W-1:0] sat_scale(input logic signed [2*W-1:0] p);
    logic signed [W+1:0] t;
    t = p[2*W-1:W-2];
    if ((t[W+1:W-1] == 3'b000) || (t[W+1:W-1] == 3'b111)) sat_scale = t[W-1:0];
    else                                                 sat_scale = t[W+1] ? SMIN : SMAX;
  endfunction

  assign scaled = sat_scale(prod_r);

  // Accumulator next value
  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD:  acc_nxt = scaled;
      ACC_ADD:   acc_nxt = sat_add(acc_r, scaled);
      ACC_CLEAR: acc_nxt = '0;
      default:   acc_nxt = acc_r;
    endcase
  end

  // Emission next value
  always_comb begin
    case (ctrl.emis_op)
      EMIS_LOAD: emis_nxt = sat_add(emis_x, emis_y);
      EMIS_ADD:  emis_nxt = sat_add(emis_r, emis_y);
      default:   emis_nxt = emis_r;
    endcase
  end

  // Product register and accumulators
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    acc_r  <= acc_nxt;
    emis_r <= emis_nxt;
  end

  assign acc  = acc_r;
  assign emis = emis_r;

endmodule

`default_nettype wire

// ----- sv/hfs_seq.sv -----
// ----------------------------------------------------------------------------
// hfs_seq
// Sequencer that steps one state item through the shared unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfs_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire hfs_pkg::stat_t stat,
  output logic                ready,
  output hfs_pkg::ctrl_t      ctrl
);
  import hfs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ready = (state_r == ST_IDLE);

  // Per-state controls and next state
  always_comb begin
    state_nxt      = state_r;
    ctrl.mul_en    = 1'b0;
    ctrl.op_sel    = OPS_UP;
    ctrl.acc_op    = ACC_HOLD;
    ctrl.emis_op   = EMIS_HOLD;
    ctrl.cap_in    = 1'b0;
    ctrl.upd_upper = 1'b0;
    ctrl.load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // upward product issues straight from the bus
        if (stat.accept) begin
          ctrl.cap_in  = 1'b1;
          ctrl.mul_en  = 1'b1;
          ctrl.emis_op = EMIS_LOAD;
          state_nxt    = ST_RT;
        end
      end
      ST_RT: begin
        ctrl.mul_en  = 1'b1;
        ctrl.op_sel  = OPS_RT;
        ctrl.acc_op  = ACC_LOAD;
        ctrl.emis_op = EMIS_ADD;
        state_nxt    = ST_DG;
      end
      ST_DG: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OPS_DG;
        ctrl.acc_op = stat.first ? ACC_CLEAR : ACC_ADD;
        state_nxt   = ST_BL;
      end
      ST_BL: begin
        ctrl.mul_en    = 1'b1;
        ctrl.op_sel    = OPS_BL;
        ctrl.acc_op    = ACC_ADD;
        ctrl.upd_upper = 1'b1;
        state_nxt      = ST_SUM;
      end
      ST_SUM: begin
        ctrl.acc_op = ACC_ADD;
        state_nxt   = ST_EM;
      end
      ST_EM: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OPS_EM;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!stat.out_stall) begin
          ctrl.load_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/hmm_forward_state_step.sv -----
// ----------------------------------------------------------------------------
// hmm_forward_state_step
// Forward-pass state update with linear-time transitions, one state per beat.
// ----------------------------------------------------------------------------
// One input beat per hidden state, in state order, in_tuser high on state
// zero. Each beat produces one alpha_out beat. in_tready drops after
// acceptance and returns once the result is loaded, so no new beat is
// taken while one is in flight: five products go one after another
// through a single WxW multiplier with its registered output, followed by
// a saturating accumulate, under a small sequencer. The result is loaded
// into the output register in state OUT, after states RT, DG, BL, SUM and
// EM; if the previous result has not been taken by then, the block waits
// until it is. Arithmetic is signed fixed point with min(WORD_BITS, 32)
// bits and two integer bits, products floored and every step saturated.
`timescale 1ns / 1ps
`default_nettype none
`include "hmm_forward_state_step_defines.svh"

module hmm_forward_state_step #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // alpha_in, suffix_next, coef_diag, coef_below, coef_up_prev, ratio_prev,
  // emit_base, emit_zero_delta, emit_two_delta, obs_zero, obs_two, zero pad
  input  wire logic [hfs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // first_state
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // alpha_out
  output logic [hfs_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import hfs_pkg::*;

  localparam int EW = (WORD_BITS > FIELD_W) ? FIELD_W : WORD_BITS;

  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  // Bus fields, low EW bits of each
  logic signed [EW-1:0] alpha_f, suffix_f, diag_f, below_f, upprev_f, ratio_f;
  logic signed [EW-1:0] ebase_f, ezero_f, etwo_f;
  logic                 obsz_f, obst_f;

  assign alpha_f  = in_tdata[OFF_ALPHA  +: EW];
  assign suffix_f = in_tdata[OFF_SUFFIX +: EW];
  assign diag_f   = in_tdata[OFF_DIAG   +: EW];
  assign below_f  = in_tdata[OFF_BELOW  +: EW];
  assign upprev_f = in_tdata[OFF_UPPREV +: EW];
  assign ratio_f  = in_tdata[OFF_RATIO  +: EW];
  assign ebase_f  = in_tdata[OFF_EBASE  +: EW];
  assign ezero_f  = in_tdata[OFF_EZERO  +: EW];
  assign etwo_f   = in_tdata[OFF_ETWO   +: EW];
  assign obsz_f   = in_tdata[OFF_OBSZ];
  assign obst_f   = in_tdata[OFF_OBST];

  // Captured operands of the beat in flight
  logic                 first_r;
  logic signed [EW-1:0] ratio_r, diag_r, below_r, suffix_r, etwo_r;
  logic                 obst_r;

  // Recurrence state
  logic signed [EW-1:0] alpha_before_r, upper_r;

  // Output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Shared unit operands and results
  logic signed [EW-1:0] op_a, op_b, emis_y, acc, emis, scaled;

  assign accept = in_tvalid && in_tready;

  assign stat.accept    = accept;
  assign stat.first     = first_r;
  assign stat.out_stall = out_valid_r && !out_tready;

  hfs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ready (in_tready),
    .ctrl  (ctrl)
  );

  // Operand pair for the multiplier
  always_comb begin
    case (ctrl.op_sel)
      OPS_RT: begin
        op_a = ratio_r;
        op_b = upper_r;
      end
      OPS_DG: begin
        op_a = diag_r;
        op_b = alpha_before_r;
      end
      OPS_BL: begin
        op_a = below_r;
        op_b = suffix_r;
      end
      OPS_EM: begin
        op_a = emis;
        op_b = acc;
      end
      default: begin
        op_a = upprev_f;
        op_b = alpha_before_r;
      end
    endcase
  end

  // Emission delta: zero delta on capture, two delta on the following cycle
  always_comb begin
    if (ctrl.cap_in) emis_y = obsz_f ? ezero_f : '0;
    else             emis_y = obst_r ? etwo_r  : '0;
  end

  hfs_mac_unit #(
    .W (EW)
  ) u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .op_a   (op_a),
    .op_b   (op_b),
    .emis_x (ebase_f),
    .emis_y (emis_y),
    .acc    (acc),
    .emis   (emis),
    .scaled (scaled)
  );

  // Operand capture
  always_ff @(posedge clk) begin
    if (ctrl.cap_in) begin
      first_r  <= in_tuser;
      ratio_r  <= ratio_f;
      diag_r   <= diag_f;
      below_r  <= below_f;
      suffix_r <= suffix_f;
      etwo_r   <= etwo_f;
      obst_r   <= obst_f;
    end
  end

  // Recurrence state; alpha_before takes the new alpha once the upward
  // product has read the old one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_before_r <= '0;
      upper_r        <= '0;
    end else begin
      if (ctrl.cap_in)    alpha_before_r <= alpha_f;
      if (ctrl.upd_upper) upper_r        <= acc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) out_data_r <= OUT_TDATA_W'(scaled);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `HFS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_tready, "ready after accept")
  `HFS_ASSERT_NOW(a_no_overwrite, clk, rst_n, ctrl.load_out, !(out_valid_r && !out_tready), "result overwritten")
  `HFS_ASSERT_NEXT(a_load_shows, clk, rst_n, ctrl.load_out, out_tvalid, "loaded result not shown")
  `HFS_ASSERT_NEXT(a_first_clears, clk, rst_n, ctrl.upd_upper && first_r, upper_r == '0, "accumulator not cleared on state zero")

endmodule

`default_nettype wire
